// File: design/ssp_pkg.sv
// ----------------------------------------------------------------------------
// ssp_pkg: shared types and constants for the sprite screen projection unit
// Configuration layout, queue entry format and divider sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package ssp_pkg;

  // Divider sizing: dividend/quotient bits and divisor bits
  localparam int DIV_N = 46;
  localparam int DIV_D = 38;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PLAYER_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLAYER_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Y    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_X  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_Y  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_W = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_H = 3'd7;

  typedef struct packed {
    logic        [15:0] player_x;
    logic        [15:0] player_y;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] plane_x;
    logic signed [15:0] plane_y;
    logic        [11:0] screen_width;
    logic        [11:0] screen_height;
  } ssp_cfg_t;

  localparam ssp_cfg_t CFG_RESET = '{
    player_x:      16'd0,
    player_y:      16'd0,
    dir_x:         16'sd16384,
    dir_y:         16'sd0,
    plane_x:       16'sd0,
    plane_y:       16'sd10813,
    screen_width:  12'd640,
    screen_height: 12'd480
  };

  // One classified request handed from front to back
  typedef struct packed {
    logic               behind;
    logic        [31:0] det;   // |det|
    logic        [31:0] ny;    // depth numerator after sign fix
    logic signed [33:0] sum;   // ny + nx after sign fix
  } ssp_job_t;

  // Control carried alongside the divider stages
  typedef struct packed {
    logic vld;
    logic behind;
    logic csign;
  } ssp_side_t;

endpackage

`default_nettype wire

// File: design/sprite_screen_projection_unit.sv
// ----------------------------------------------------------------------------
// sprite_screen_projection_unit: raycaster sprite projection top level
// Projects one sprite map position to depth, screen column, size and bounds.
// ----------------------------------------------------------------------------
// Usage:
//  - Load player position, direction, camera plane and screen size through
//    the cfg_ write port while no request is in flight.
//  - Input channel (in_valid / in_stall) takes one sprite position per
//    request; result channel (out_valid / out_stall) gives one result each.
//  - Throughput: one request per cycle, sustained while out_stall stays low.
//  - Path from acceptance to out_valid: two front stages, the queue write,
//    the numerator stage, 46 divider stages (one quotient bit per stage)
//    and two formatting stages.
//  - A four-entry queue separates the front from the back; when the
//    receiver stalls, the back pipeline holds, the queue fills and then
//    in_stall rises. Results are held stable while out_stall is high.
//  - Reset clears all pipeline valids and the queue and loads the default
//    camera (facing +x, 640x480 screen).
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_screen_projection_unit import ssp_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [15:0]           in_sprite_x,
  input  wire logic [15:0]           in_sprite_y,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_behind,
  output logic [22:0]                out_depth,
  output logic [15:0]                out_center_column,
  output logic [15:0]                out_sprite_size,
  output logic [14:0]                out_draw_start_x,
  output logic [15:0]                out_draw_end_x,
  output logic [10:0]                out_draw_start_y,
  output logic [10:0]                out_draw_end_y
);

  ssp_cfg_t cfg_r;
  ssp_job_t push_job, head_job;
  logic     push, pop, q_full, q_empty;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PLAYER_X: cfg_r.player_x      <= cfg_wdata;
        REG_PLAYER_Y: cfg_r.player_y      <= cfg_wdata;
        REG_DIR_X:    cfg_r.dir_x         <= cfg_wdata;
        REG_DIR_Y:    cfg_r.dir_y         <= cfg_wdata;
        REG_PLANE_X:  cfg_r.plane_x       <= cfg_wdata;
        REG_PLANE_Y:  cfg_r.plane_y       <= cfg_wdata;
        REG_SCREEN_W: cfg_r.screen_width  <= cfg_wdata[11:0];
        REG_SCREEN_H: cfg_r.screen_height <= cfg_wdata[11:0];
        default:      cfg_r               <= cfg_r;
      endcase
    end
  end

  ssp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_sprite_x (in_sprite_x),
    .in_sprite_y (in_sprite_y),
    .q_full      (q_full),
    .push        (push),
    .job         (push_job)
  );

  ssp_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (push_job),
    .pop   (pop),
    .rdata (head_job),
    .full  (q_full),
    .empty (q_empty)
  );

  ssp_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .head              (head_job),
    .q_empty           (q_empty),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_behind        (out_behind),
    .out_depth         (out_depth),
    .out_center_column (out_center_column),
    .out_sprite_size   (out_sprite_size),
    .out_draw_start_x  (out_draw_start_x),
    .out_draw_end_x    (out_draw_end_x),
    .out_draw_start_y  (out_draw_start_y),
    .out_draw_end_y    (out_draw_end_y)
  );

endmodule

`default_nettype wire

// File: design/ssp_div.sv
// ----------------------------------------------------------------------------
// ssp_div: pipelined restoring divider
// One quotient bit per stage, DIV_N stages, advances on en.
// ----------------------------------------------------------------------------
`default_nettype none

module ssp_div import ssp_pkg::*; (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [DIV_N-1:0] dividend,
  input  wire logic [DIV_D-1:0] divisor,
  output logic      [DIV_N-1:0] quotient
);

  logic [DIV_D-1:0] rem_r   [DIV_N];
  logic [DIV_N-1:0] nq_r    [DIV_N];
  logic [DIV_D-1:0] dv_r    [DIV_N];
  logic [DIV_D-1:0] rem_in  [DIV_N];
  logic [DIV_N-1:0] nq_in   [DIV_N];
  logic [DIV_D-1:0] dv_in   [DIV_N];
  logic [DIV_D:0]   trial   [DIV_N];
  logic [DIV_D:0]   diff    [DIV_N];
  logic             ge      [DIV_N];
  logic [DIV_D-1:0] rem_nxt [DIV_N];
  logic [DIV_N-1:0] nq_nxt  [DIV_N];

  // stage inputs: first stage from ports, others from previous stage
  always_comb begin
    rem_in[0] = '0;
    nq_in[0]  = dividend;
    dv_in[0]  = divisor;
    for (int s = 1; s < DIV_N; s++) begin
      rem_in[s] = rem_r[s-1];
      nq_in[s]  = nq_r[s-1];
      dv_in[s]  = dv_r[s-1];
    end
  end

  // one trial subtract per stage; quotient bits shift in at the bottom
  always_comb begin
    for (int s = 0; s < DIV_N; s++) begin
      trial[s]   = {rem_in[s], nq_in[s][DIV_N-1]};
      diff[s]    = trial[s] - {1'b0, dv_in[s]};
      ge[s]      = (trial[s] >= {1'b0, dv_in[s]});
      rem_nxt[s] = ge[s] ? diff[s][DIV_D-1:0] : trial[s][DIV_D-1:0];
      nq_nxt[s]  = {nq_in[s][DIV_N-2:0], ge[s]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < DIV_N; s++) begin
        rem_r[s] <= rem_nxt[s];
        nq_r[s]  <= nq_nxt[s];
        dv_r[s]  <= dv_in[s];
      end
    end
  end

  assign quotient = nq_r[DIV_N-1];

endmodule

`default_nettype wire

// File: design/ssp_queue.sv
// ----------------------------------------------------------------------------
// ssp_queue: short request queue between front and back
// QDEPTH entries, registered storage, head read combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module ssp_queue import ssp_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire ssp_job_t wdata,
  input  wire logic     pop,
  output ssp_job_t      rdata,
  output logic          full,
  output logic          empty
);

  ssp_job_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;

  assign full  = (count_r == (QPTR_W+1)'(QDEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

`ifndef SYNTH
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (QPTR_W+1)'(QDEPTH))
    else $error("queue count overflow");
`endif

endmodule

`default_nettype wire

// File: design/ssp_front.sv
// ----------------------------------------------------------------------------
// ssp_front: request intake and classification
// Offsets, camera products, determinant sign fix and behind test.
// ----------------------------------------------------------------------------
`default_nettype none

module ssp_front import ssp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire ssp_cfg_t    cfg,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_sprite_x,
  input  wire logic [15:0] in_sprite_y,
  input  wire logic        q_full,
  output logic             push,
  output ssp_job_t         job
);

  logic adv;
  logic f1_vld_r, f2_vld_r;

  logic signed [16:0] dx_nxt, dy_nxt, dx_r, dy_r;
  logic signed [31:0] pdet_a_nxt, pdet_b_nxt, pdet_a_r, pdet_b_r;
  logic signed [32:0] pnx_a_nxt, pnx_b_nxt, pny_a_nxt, pny_b_nxt;
  logic signed [32:0] pnx_a_r, pnx_b_r, pny_a_r, pny_b_r;
  logic signed [32:0] det, det_f;
  logic signed [33:0] nx, ny, nx_f, ny_f;

  assign adv      = !q_full;
  assign in_stall = q_full;

  // stage 1: offsets from the player
  assign dx_nxt = $signed({1'b0, in_sprite_x}) - $signed({1'b0, cfg.player_x});
  assign dy_nxt = $signed({1'b0, in_sprite_y}) - $signed({1'b0, cfg.player_y});

  // stage 2: camera products
  assign pdet_a_nxt = 32'(cfg.plane_x) * 32'(cfg.dir_y);
  assign pdet_b_nxt = 32'(cfg.dir_x) * 32'(cfg.plane_y);
  assign pnx_a_nxt  = 33'(cfg.dir_y) * 33'(dx_r);
  assign pnx_b_nxt  = 33'(cfg.dir_x) * 33'(dy_r);
  assign pny_a_nxt  = 33'(cfg.plane_x) * 33'(dy_r);
  assign pny_b_nxt  = 33'(cfg.plane_y) * 33'(dx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
      f2_vld_r <= 1'b0;
    end else if (adv) begin
      f1_vld_r <= in_valid;
      f2_vld_r <= f1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx_r     <= dx_nxt;
      dy_r     <= dy_nxt;
      pdet_a_r <= pdet_a_nxt;
      pdet_b_r <= pdet_b_nxt;
      pnx_a_r  <= pnx_a_nxt;
      pnx_b_r  <= pnx_b_nxt;
      pny_a_r  <= pny_a_nxt;
      pny_b_r  <= pny_b_nxt;
    end
  end

  // determinant and numerators, flipped so det is non-negative
  always_comb begin
    det   = 33'(pdet_a_r) - 33'(pdet_b_r);
    nx    = 34'(pnx_a_r) - 34'(pnx_b_r);
    ny    = 34'(pny_a_r) - 34'(pny_b_r);
    det_f = det[32] ? -det : det;
    nx_f  = det[32] ? -nx : nx;
    ny_f  = det[32] ? -ny : ny;

    job.behind = (det_f == '0) || ny_f[33] || (ny_f == '0);
    job.det    = det_f[31:0];
    job.ny     = ny_f[31:0];
    job.sum    = nx_f + ny_f;
  end

  assign push = f2_vld_r && adv;

endmodule

`default_nettype wire

// File: design/ssp_back.sv
// ----------------------------------------------------------------------------
// ssp_back: projection arithmetic and result formatting
// Numerators, three pipelined divides, saturation, clamps, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ssp_back import ssp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire ssp_cfg_t    cfg,
  input  wire ssp_job_t    head,
  input  wire logic        q_empty,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_behind,
  output logic [22:0]      out_depth,
  output logic [15:0]      out_center_column,
  output logic [15:0]      out_sprite_size,
  output logic [14:0]      out_draw_start_x,
  output logic [15:0]      out_draw_end_x,
  output logic [10:0]      out_draw_start_y,
  output logic [10:0]      out_draw_end_y
);

  logic adv;
  logic out_vld_r;

  // output registers
  logic        out_behind_r;
  logic [22:0] out_depth_r;
  logic [15:0] out_center_r;
  logic [15:0] out_size_r;
  logic [14:0] out_sxs_r;
  logic [15:0] out_sxe_r;
  logic [10:0] out_sys_r;
  logic [10:0] out_sye_r;

  // stage B0 registers
  ssp_side_t        b0_r;
  logic [DIV_N-1:0] dnum_r, cnum_r, snum_r;
  logic [DIV_D-1:0] ddiv_r, cdiv_r, sdiv_r;
  logic [33:0]      mag;

  // side line alongside divider stages
  ssp_side_t        sb_r [DIV_N];
  logic [DIV_N-1:0] dq, cq, sq;

  // stage P1
  logic               p1_vld_r, p1_behind_r;
  logic signed [46:0] p1_center_nxt, p1_center_r;
  logic [44:0]        p1_half_r;
  logic [22:0]        p1_depth_nxt, p1_depth_r;
  logic [15:0]        p1_size_nxt, p1_size_r;

  // stage P2
  logic signed [47:0] c48, h48, w48, hh48, ht48;
  logic signed [47:0] sxs, sxe, sxe_c, sys, sye, sye_c;
  logic [15:0] cc_nxt;
  logic [14:0] sxs_nxt;
  logic [15:0] sxe_nxt;
  logic [10:0] sys_nxt, sye_nxt;

  assign adv = !out_vld_r || !out_stall;
  assign pop = adv && !q_empty;

  // B0: numerators and divisors
  assign mag = head.sum[33] ? 34'(-head.sum) : 34'(head.sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_r <= '0;
    end else if (adv) begin
      b0_r.vld    <= pop;
      b0_r.behind <= head.behind;
      b0_r.csign  <= head.sum[33];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dnum_r <= {head.ny, 14'b0};
      cnum_r <= 46'(cfg.screen_width[11:1]) * 46'(mag[32:0]);
      snum_r <= 46'(cfg.screen_height) * 46'(head.det);
      ddiv_r <= 38'(head.det);
      cdiv_r <= 38'(head.ny);
      sdiv_r <= {head.ny, 6'b0};
    end
  end

  ssp_div u_div_depth (.clk(clk), .en(adv), .dividend(dnum_r), .divisor(ddiv_r),
                       .quotient(dq));
  ssp_div u_div_center (.clk(clk), .en(adv), .dividend(cnum_r), .divisor(cdiv_r),
                        .quotient(cq));
  ssp_div u_div_size (.clk(clk), .en(adv), .dividend(snum_r), .divisor(sdiv_r),
                      .quotient(sq));

  // control line matching the divider depth
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < DIV_N; s++) sb_r[s] <= '0;
    end else if (adv) begin
      sb_r[0] <= b0_r;
      for (int s = 1; s < DIV_N; s++) sb_r[s] <= sb_r[s-1];
    end
  end

  // P1: signed center, half size, saturated depth and size
  assign p1_center_nxt = sb_r[DIV_N-1].csign ? -$signed({1'b0, cq}) : $signed({1'b0, cq});
  assign p1_depth_nxt  = (dq > 46'h7FFFFF) ? 23'h7FFFFF : dq[22:0];
  assign p1_size_nxt   = (sq > 46'hFFFF) ? 16'hFFFF : sq[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else if (adv) begin
      p1_vld_r <= sb_r[DIV_N-1].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_behind_r <= sb_r[DIV_N-1].behind;
      p1_center_r <= p1_center_nxt;
      p1_half_r   <= sq[DIV_N-1:1];
      p1_depth_r  <= p1_depth_nxt;
      p1_size_r   <= p1_size_nxt;
    end
  end

  // P2: draw bounds with clamps
  always_comb begin
    c48  = 48'(p1_center_r);
    h48  = $signed({3'b0, p1_half_r});
    w48  = $signed(48'(cfg.screen_width));
    ht48 = $signed(48'(cfg.screen_height));
    hh48 = $signed(48'(cfg.screen_height[11:1]));

    sxs   = c48 - h48;
    sxe   = c48 + h48;
    sxe_c = (sxe >= w48) ? (w48 - 48'sd1) : sxe;
    sys   = hh48 - h48;
    sye   = hh48 + h48;
    sye_c = (sye >= ht48) ? (ht48 - 48'sd1) : sye;

    if (c48 > 48'sd32767)       cc_nxt = 16'h7FFF;
    else if (c48 < -48'sd32768) cc_nxt = 16'h8000;
    else                        cc_nxt = c48[15:0];

    if (sxs < 48'sd0)           sxs_nxt = '0;
    else if (sxs > 48'sd32767)  sxs_nxt = 15'h7FFF;
    else                        sxs_nxt = sxs[14:0];

    if (sxe_c < -48'sd32768)    sxe_nxt = 16'h8000;
    else                        sxe_nxt = sxe_c[15:0];

    if (sys < 48'sd0)           sys_nxt = '0;
    else                        sys_nxt = sys[10:0];

    if (sye_c < 48'sd0)         sye_nxt = '0;
    else if (sye_c > 48'sd2047) sye_nxt = 11'h7FF;
    else                        sye_nxt = sye_c[10:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_behind_r <= p1_behind_r;
      if (p1_behind_r) begin
        out_depth_r  <= '0;
        out_center_r <= '0;
        out_size_r   <= '0;
        out_sxs_r    <= '0;
        out_sxe_r    <= '0;
        out_sys_r    <= '0;
        out_sye_r    <= '0;
      end else begin
        out_depth_r  <= p1_depth_r;
        out_center_r <= cc_nxt;
        out_size_r   <= p1_size_r;
        out_sxs_r    <= sxs_nxt;
        out_sxe_r    <= sxe_nxt;
        out_sys_r    <= sys_nxt;
        out_sye_r    <= sye_nxt;
      end
    end
  end

  assign out_valid         = out_vld_r;
  assign out_behind        = out_behind_r;
  assign out_depth         = out_depth_r;
  assign out_center_column = out_center_r;
  assign out_sprite_size   = out_size_r;
  assign out_draw_start_x  = out_sxs_r;
  assign out_draw_end_x    = out_sxe_r;
  assign out_draw_start_y  = out_sys_r;
  assign out_draw_end_y    = out_sye_r;

endmodule

`default_nettype wire

// File: bench/ssp_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ssp_checker: result predictor and scoreboard for the sprite projection unit
// Tracks the camera registers from the write port, predicts each accepted
// request and compares each accepted result field by field, in order.
// ----------------------------------------------------------------------------
module ssp_checker import ssp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [15:0]           in_sprite_x,
  input  logic [15:0]           in_sprite_y,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic                  out_behind,
  input  logic [22:0]           out_depth,
  input  logic [15:0]           out_center_column,
  input  logic [15:0]           out_sprite_size,
  input  logic [14:0]           out_draw_start_x,
  input  logic [15:0]           out_draw_end_x,
  input  logic [10:0]           out_draw_start_y,
  input  logic [10:0]           out_draw_end_y,
  output int                    pending,
  output int                    fail_count,
  output int                    n_checked,
  output int                    n_behind
);

  typedef struct packed {
    logic        behind;
    logic [22:0] depth;
    logic [15:0] center;
    logic [15:0] size;
    logic [14:0] start_x;
    logic [15:0] end_x;
    logic [10:0] start_y;
    logic [10:0] end_y;
  } projection_t;

  ssp_cfg_t    camera;
  projection_t projections[$];

  assign pending = projections.size();

  function automatic longint sat(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Exact integer projection of one sprite against the current camera
  function automatic projection_t project(logic [15:0] sx, logic [15:0] sy);
    longint dx, dy, det, nx, ny, w, h, dpt, ctr, sz, half, xs, xe, ys, ye;
    projection_t r;
    r  = '0;
    dx = longint'(sx) - longint'(camera.player_x);
    dy = longint'(sy) - longint'(camera.player_y);
    w  = longint'(camera.screen_width);
    h  = longint'(camera.screen_height);
    det = longint'(camera.plane_x) * longint'(camera.dir_y)
        - longint'(camera.dir_x) * longint'(camera.plane_y);
    nx = longint'(camera.dir_y) * dx - longint'(camera.dir_x) * dy;
    ny = longint'(camera.plane_x) * dy - longint'(camera.plane_y) * dx;
    if (det < 0) begin
      det = -det;
      nx  = -nx;
      ny  = -ny;
    end
    // singular camera or sprite not in front
    if (det == 0 || ny <= 0) begin
      r.behind = 1'b1;
      return r;
    end
    dpt  = (ny * 16384) / det;
    ctr  = ((w / 2) * (ny + nx)) / ny;
    sz   = (h * det) / (ny * 64);
    half = sz / 2;
    ys = h / 2 - half;
    if (ys < 0) ys = 0;
    ye = h / 2 + half;
    if (ye >= h) ye = h - 1;
    xs = ctr - half;
    if (xs < 0) xs = 0;
    xe = ctr + half;
    if (xe >= w) xe = w - 1;
    r.depth   = 23'(sat(dpt, 0, 8388607));
    r.center  = 16'(sat(ctr, -32768, 32767));
    r.size    = 16'(sat(sz, 0, 65535));
    r.start_x = 15'(sat(xs, 0, 32767));
    r.end_x   = 16'(sat(xe, -32768, 32767));
    r.start_y = 11'(sat(ys, 0, 2047));
    r.end_y   = 11'(sat(ye, 0, 2047));
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] mismatch on %s: got %0h expected %0h", $time, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    n_checked  = 0;
    n_behind   = 0;
  end

  // Camera register shadow
  always @(posedge clk) begin
    if (!rst_n) begin
      camera <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PLAYER_X: camera.player_x      <= cfg_wdata;
        REG_PLAYER_Y: camera.player_y      <= cfg_wdata;
        REG_DIR_X:    camera.dir_x         <= cfg_wdata;
        REG_DIR_Y:    camera.dir_y         <= cfg_wdata;
        REG_PLANE_X:  camera.plane_x       <= cfg_wdata;
        REG_PLANE_Y:  camera.plane_y       <= cfg_wdata;
        REG_SCREEN_W: camera.screen_width  <= cfg_wdata[11:0];
        REG_SCREEN_H: camera.screen_height <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  // Predict on request, compare on result
  always @(posedge clk) begin
    projection_t want;
    if (rst_n && in_valid && !in_stall)
      projections.push_back(project(in_sprite_x, in_sprite_y));
    if (rst_n && out_valid && !out_stall) begin
      if (projections.size() == 0) begin
        $display("[%0t] result with no request outstanding", $time);
        fail_count++;
      end else begin
        want = projections.pop_front();
        n_checked++;
        if (want.behind) n_behind++;
        if (out_behind != want.behind) report_mismatch("behind", out_behind, want.behind);
        if (out_depth != want.depth) report_mismatch("depth", out_depth, want.depth);
        if (out_center_column != want.center)
          report_mismatch("center_column", out_center_column, want.center);
        if (out_sprite_size != want.size)
          report_mismatch("sprite_size", out_sprite_size, want.size);
        if (out_draw_start_x != want.start_x)
          report_mismatch("draw_start_x", out_draw_start_x, want.start_x);
        if (out_draw_end_x != want.end_x)
          report_mismatch("draw_end_x", out_draw_end_x, want.end_x);
        if (out_draw_start_y != want.start_y)
          report_mismatch("draw_start_y", out_draw_start_y, want.start_y);
        if (out_draw_end_y != want.end_y)
          report_mismatch("draw_end_y", out_draw_end_y, want.end_y);
      end
    end
  end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: sprite screen projection unit
// Drives camera setups and sprite requests with random idling and stalls;
// the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench import ssp_pkg::*;;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 300;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic [15:0]           in_sprite_x;
  logic [15:0]           in_sprite_y;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_behind;
  logic [22:0]           out_depth;
  logic [15:0]           out_center_column;
  logic [15:0]           out_sprite_size;
  logic [14:0]           out_draw_start_x;
  logic [15:0]           out_draw_end_x;
  logic [10:0]           out_draw_start_y;
  logic [10:0]           out_draw_end_y;

  int pending, fail_count, n_checked, n_behind;
  int hold_token;     // bumped by stimulus to ask for a long receiver hold-off
  bit steady;         // no idling on either side
  int n_setups;
  logic [15:0] pos_x, pos_y;

  sprite_screen_projection_unit i_dut (.*);

  ssp_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: random stalls, or a long counted hold-off on request
  initial begin
    int seen, hold;
    seen = 0;
    hold = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_token != seen) begin
        seen = hold_token;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !steady && ($urandom_range(99) < 28);
      end
    end
  end

  // Watchdog on cycles with no traffic
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", pending);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic load_camera(logic [15:0] px, logic [15:0] py, logic [15:0] dx,
                             logic [15:0] dy, logic [15:0] qx, logic [15:0] qy,
                             logic [15:0] w, logic [15:0] h);
    write_reg(REG_PLAYER_X, px);
    write_reg(REG_PLAYER_Y, py);
    write_reg(REG_DIR_X, dx);
    write_reg(REG_DIR_Y, dy);
    write_reg(REG_PLANE_X, qx);
    write_reg(REG_PLANE_Y, qy);
    write_reg(REG_SCREEN_W, w);
    write_reg(REG_SCREEN_H, h);
    pos_x = px;
    pos_y = py;
    n_setups++;
  endtask

  // Sender waits out all results before touching the registers
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic send_sprite(logic [15:0] sx, logic [15:0] sy);
    while (!steady && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_sprite_x <= sx;
    in_sprite_y <= sy;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  function automatic logic [15:0] pick_axis();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'h8000;
      2: return 16'h7FFF;
      3: return 16'hFFFF;
      4: return 16'h4000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_screen();
    case ($urandom_range(6))
      0: return 16'd1;
      1: return 16'd2048;
      2: return 16'hFFFF;
      3: return 16'd0;
      default: return 16'($urandom_range(1, 2048)) | (16'($urandom) & 16'hF000);
    endcase
  endfunction

  initial begin
    logic [15:0] ax, ay;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_wdata   = '0;
    in_valid    = 1'b0;
    in_sprite_x = '0;
    in_sprite_y = '0;
    hold_token  = 0;
    steady      = 1'b0;
    n_setups    = 0;
    pos_x       = '0;
    pos_y       = '0;
    rst_n       = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset camera: sprite at the player, just ahead, far corner, edges
    send_sprite(16'h0000, 16'h0000);
    send_sprite(16'h0100, 16'h0000);
    send_sprite(16'h0001, 16'h0000);
    send_sprite(16'h0001, 16'hFFFF);
    send_sprite(16'hFFFF, 16'hFFFF);
    send_sprite(16'hFFFF, 16'h0000);
    send_sprite(16'h0000, 16'h8000);
    send_sprite(16'h0800, 16'h0080);
    send_sprite(16'h0400, 16'hFF00);
    drain();

    // Player at the far corner; every sprite offset is zero or negative
    load_camera(16'hFFFF, 16'hFFFF, 16'hC000, 16'h0000, 16'h0000, 16'hD5C3,
                16'd2048, 16'd2048);
    send_sprite(16'h0000, 16'h0000);
    send_sprite(16'hFF00, 16'hFFFF);
    send_sprite(16'hFFFE, 16'hFFFF);
    send_sprite(16'h7FFF, 16'hFFF0);
    drain();

    // Singular camera: plane parallel to direction
    load_camera(16'h1000, 16'h1000, 16'h4000, 16'h4000, 16'h2000, 16'h2000,
                16'd1, 16'd1);
    send_sprite(16'h2000, 16'h1800);
    send_sprite(16'h0000, 16'hFFFF);
    drain();

    // Extreme axes, tiny screen, zero height
    load_camera(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000,
                16'd1, 16'd0);
    send_sprite(16'h8001, 16'h8000);
    send_sprite(16'h7FFF, 16'h8001);
    send_sprite(16'hFFFF, 16'h0000);
    drain();

    // Random setups, sprites mostly near the player so many land in front
    for (int s = 0; s < 12; s++) begin
      load_camera(16'($urandom), 16'($urandom), pick_axis(), pick_axis(),
                  pick_axis(), pick_axis(), pick_screen(), pick_screen());
      steady = (s == 5);
      if (s == 3) hold_token++;
      for (int k = 0; k < 50; k++) begin
        if ($urandom_range(3) != 0) begin
          ax = pos_x + 16'($urandom_range(0, 4095)) - 16'd2048;
          ay = pos_y + 16'($urandom_range(0, 4095)) - 16'd2048;
        end else begin
          ax = 16'($urandom);
          ay = 16'($urandom);
        end
        send_sprite(ax, ay);
      end
      steady = 1'b0;
      drain();
    end

    repeat (60) @(negedge clk);
    $display("covered %0d camera setups, %0d results checked, %0d behind the camera",
             n_setups + 1, n_checked, n_behind);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: sprite_screen_projection_unit.f
design/ssp_pkg.sv
design/ssp_div.sv
design/ssp_queue.sv
design/ssp_front.sv
design/ssp_back.sv
design/sprite_screen_projection_unit.sv
bench/ssp_checker.sv
bench/testbench.sv
